// ===== hw/rtl/wesp_pkg.sv =====
`timescale 1ns / 1ps

package wesp_pkg;

  // field widths
  localparam int DELTA_W  = 18;
  localparam int PERIOD_W = 16;
  localparam int SPEED_W  = 31;

  // mm/s scale from um per us
  localparam int SCALE   = 1000;
  localparam int SCALE_W = 10;

  localparam int WINDOW_SIZE_DEFAULT = 5;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10000;

endpackage

// ===== hw/rtl/windowed_encoder_speed_estimator.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake                 payload
// s_axis    in   s_tvalid / s_tready       s_tdata delta_um, s_tuser clear_window
// m_axis    out  m_tvalid / m_tready       m_tdata speed_mm_per_s
// cfg       in   cfg_valid / cfg_ready     cfg_data sample_period_us
//
// an accepted word passes the ring update, the scale and divisor product, the
// restoring divider with one quotient bit per cycle over the MAG_W = SUM_W + 10
// dividend bits, then the output register; a clear_window word skips to that with zero.
// the next word is taken only once the result has reached the output register.
// reset clears the window, the handshake state and loads a period of 10000 us.
// a waiting result lets one more word in, whose result then stalls in the final step.

module windowed_encoder_speed_estimator #(
  parameter int WINDOW_SIZE = wesp_pkg::WINDOW_SIZE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // slave side
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,   // [17:0] delta_um, rest zero
  input  logic [0:0]                    s_tuser,   // [0] clear_window
  // master side
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,   // [30:0] speed_mm_per_s, [31] zero
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wesp_pkg::PERIOD_W-1:0] cfg_data   // [15:0] sample_period_us
);

  localparam int DELTA_W  = wesp_pkg::DELTA_W;
  localparam int PERIOD_W = wesp_pkg::PERIOD_W;
  localparam int SPEED_W  = wesp_pkg::SPEED_W;
  // running sum of the window, signed
  localparam int SUM_W    = DELTA_W + $clog2(WINDOW_SIZE);
  // magnitude of sum times scale
  localparam int MAG_W    = SUM_W + wesp_pkg::SCALE_W;
  localparam int FILL_W   = $clog2(WINDOW_SIZE + 1);
  localparam int SLOT_W   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int DIV_W    = FILL_W + PERIOD_W;
  localparam int CNT_W    = $clog2(MAG_W + 1);
  localparam int EXT_W    = ((MAG_W > SPEED_W) ? MAG_W : SPEED_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t                state;
  logic [PERIOD_W-1:0]   period;
  logic [DELTA_W-1:0]    delta;
  logic                  clr;
  logic [DELTA_W-1:0]    ring [WINDOW_SIZE];
  logic [DELTA_W-1:0]    oldest;
  logic signed [SUM_W-1:0] window_sum;
  logic [SLOT_W-1:0]     write_slot;
  logic [FILL_W-1:0]     fill_count;
  logic                  neg;
  logic [MAG_W-1:0]      dvd;
  logic [DIV_W-1:0]      rem;
  logic [DIV_W-1:0]      dvsr;
  logic [CNT_W-1:0]      cnt;
  logic [SPEED_W-1:0]    speed;

  logic                  in_acc;
  logic                  full;
  logic signed [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0]      sum_mag;
  logic [PERIOD_W-1:0]   period_eff;
  logic [DIV_W:0]        rem_shift;
  logic                  q_bit;
  logic [EXT_W-1:0]      qx;
  logic [EXT_W-1:0]      pos_max;
  logic [EXT_W-1:0]      neg_max;
  logic [EXT_W-1:0]      res_ext;

  // no word or register write is taken while in reset
  assign s_tready  = !rst && (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_ready = !rst;
  assign m_tdata   = {1'b0, speed};

  // oldest sample leaves once the window is full
  assign full     = (fill_count == FILL_W'(WINDOW_SIZE));
  assign sum_next = window_sum
                  - (full ? SUM_W'(signed'(oldest)) : SUM_W'(0))
                  + SUM_W'(signed'(delta));

  assign sum_mag    = window_sum[SUM_W-1] ? SUM_W'(-window_sum) : SUM_W'(window_sum);
  assign period_eff = (period == '0) ? PERIOD_W'(1) : period;

  // restoring divider, one quotient bit per cycle
  assign rem_shift = {rem, dvd[MAG_W-1]};
  assign q_bit     = (rem_shift >= {1'b0, dvsr});

  // saturate magnitude, then apply sign
  assign qx      = EXT_W'(dvd);
  assign pos_max = (EXT_W'(1) << (SPEED_W - 1)) - EXT_W'(1);
  assign neg_max = EXT_W'(1) << (SPEED_W - 1);
  always_comb begin
    if (neg) begin
      res_ext = (qx > neg_max) ? -neg_max : -qx;
    end else begin
      res_ext = (qx > pos_max) ? pos_max : qx;
    end
  end

  // sample ring, registered read of the slot about to be overwritten
  always_ff @(posedge clk) begin
    if (in_acc) begin
      oldest <= ring[write_slot];
    end
    if (state == ST_UPDATE) begin
      ring[write_slot] <= delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      period     <= wesp_pkg::PERIOD_RESET;
      window_sum <= '0;
      write_slot <= '0;
      fill_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        period <= cfg_data;
      end
      // the final step sets valid itself when it hands over a new result
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            delta <= s_tdata[DELTA_W-1:0];
            clr   <= s_tuser[0];
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (clr) begin
            // window empties, result forced to zero
            window_sum <= '0;
            write_slot <= '0;
            fill_count <= '0;
            dvd        <= '0;
            neg        <= 1'b0;
            state      <= ST_FIN;
          end else begin
            window_sum <= sum_next;
            write_slot <= (write_slot == SLOT_W'(WINDOW_SIZE - 1)) ? '0
                        : write_slot + SLOT_W'(1);
            if (!full) begin
              fill_count <= fill_count + FILL_W'(1);
            end
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          neg   <= window_sum[SUM_W-1];
          dvd   <= MAG_W'(sum_mag) * MAG_W'(wesp_pkg::SCALE);
          dvsr  <= DIV_W'(fill_count) * DIV_W'(period_eff);
          rem   <= '0;
          cnt   <= CNT_W'(MAG_W);
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= q_bit ? DIV_W'(rem_shift - {1'b0, dvsr}) : rem_shift[DIV_W-1:0];
          dvd <= {dvd[MAG_W-2:0], q_bit};
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            speed    <= res_ext[SPEED_W-1:0];
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(WINDOW_SIZE))
    else $error("fill count beyond window");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot <= SLOT_W'(WINDOW_SIZE - 1))
    else $error("write slot beyond window");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (dvsr != '0))
    else $error("divide by zero");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && clr) |=> (fill_count == '0 && window_sum == '0))
    else $error("clear left window state");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < dvsr))
    else $error("remainder not below divisor");

endmodule
